@@ design/multi_channel_byte_fifo_bank_core_macros.svh @@
// Assertion macros shared by the byte FIFO bank checker.
`ifndef MULTI_CHANNEL_BYTE_FIFO_BANK_CORE_MACROS_SVH
`define MULTI_CHANNEL_BYTE_FIFO_BANK_CORE_MACROS_SVH

// Implication in the same cycle, disabled during reset.
`define MCFB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication checked in the next cycle, disabled during reset.
`define MCFB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Implication with no reset qualifier.
`define MCFB_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

@@ design/mcfb_pkg.sv @@
// Package: types, codes and defaults for the byte FIFO bank.
`default_nettype none
package mcfb_pkg;

   localparam int NUM_CHANNELS_DEF = 4;
   localparam int QUEUE_DEPTH_DEF  = 32;

   localparam logic [1:0] ACT_PUSH  = 2'd0;
   localparam logic [1:0] ACT_POP   = 2'd1;
   localparam logic [1:0] ACT_CHECK = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_EMPTY   = 2'd2;
   localparam logic [1:0] ST_BADCHAN = 2'd3;

   typedef struct packed {
      logic [1:0] action;
      logic [3:0] channel;
      logic       direction;
      logic [7:0] data_in;
   } req_type;

   typedef struct packed {
      logic [7:0] data_out;
      logic [1:0] status;
   } rsp_type;

endpackage
`default_nettype wire

@@ design/mcfb_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module mcfb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

@@ design/multi_channel_byte_fifo_bank_core.sv @@
// A word taken on req passes through the s1 stage register and then the rsp output register.
// Throughput: one word per cycle while rsp is not stalled; pointers sit in flops and a push or pop
// touches one storage RAM port per cycle, so nothing blocks the next word.
// A stalled result holds the pop stage; req stalls only when both stages are full.
// Reset clears all read and write pointers (every queue empty); storage is not cleared.
`default_nettype none
module multi_channel_byte_fifo_bank_core #(
   parameter int NUM_CHANNELS = mcfb_pkg::NUM_CHANNELS_DEF,
   parameter int QUEUE_DEPTH  = mcfb_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire mcfb_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output mcfb_pkg::rsp_type     rsp_data
);

   localparam int QC = 2 * NUM_CHANNELS;
   localparam int QW = $clog2(QC);
   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int RAM_DEPTH = QC * (2 ** PW);
   localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);

   logic [PW-1:0] wp_ff [QC];
   logic [PW-1:0] rp_ff [QC];

   logic          s1_valid_ff, s1_valid_in;
   logic [1:0]    s1_status_ff, s1_status_in;
   logic          s1_pop_ff, s1_pop_in;
   logic          rsp_valid_ff, rsp_valid_in;
   mcfb_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic          req_accept, s1_move, ch_ok, full, empty;
   logic          push_do, pop_do;
   logic [QW-1:0] q;
   logic [PW-1:0] wp, rp, wp_next, rp_next;
   logic [7:0]    ram_rd_data;

   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_move;
   assign req_accept = req_valid && !req_stall;

   assign ch_ok   = {1'b0, req_data.channel} < 5'(NUM_CHANNELS);
   assign q       = QW'({req_data.channel, req_data.direction});
   assign wp      = wp_ff[q];
   assign rp      = rp_ff[q];
   assign wp_next = (wp == PTR_LAST) ? '0 : wp + 1'b1;
   assign rp_next = (rp == PTR_LAST) ? '0 : rp + 1'b1;
   assign full    = (wp_next == rp);
   assign empty   = (wp == rp);

   always_comb begin
      push_do   = 1'b0;
      pop_do    = 1'b0;
      s1_status_in = mcfb_pkg::ST_OK;
      if (!ch_ok) begin
         s1_status_in = mcfb_pkg::ST_BADCHAN;
      end else begin
         unique case (req_data.action)
            mcfb_pkg::ACT_PUSH: begin
               push_do      = !full;
               s1_status_in = full ? mcfb_pkg::ST_FULL : mcfb_pkg::ST_OK;
            end
            mcfb_pkg::ACT_POP: begin
               pop_do       = !empty;
               s1_status_in = empty ? mcfb_pkg::ST_EMPTY : mcfb_pkg::ST_OK;
            end
            mcfb_pkg::ACT_CHECK: begin
               s1_status_in = full ? mcfb_pkg::ST_FULL : mcfb_pkg::ST_OK;
            end
            default: begin
               s1_status_in = mcfb_pkg::ST_OK;
            end
         endcase
      end
   end

   assign s1_pop_in   = pop_do;
   assign s1_valid_in = req_accept || (s1_valid_ff && !s1_move);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && rsp_stall);

   always_comb begin
      rsp_data_in.status   = s1_status_ff;
      rsp_data_in.data_out = s1_pop_ff ? ram_rd_data : 8'd0;
   end

   // RAM read only fires on a new word, so its output holds while s1 waits
   mcfb_ram #(
      .WIDTH(8),
      .DEPTH(RAM_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (req_accept && push_do),
      .wr_addr({q, wp}),
      .wr_data(req_data.data_in),
      .rd_en  (req_accept && pop_do),
      .rd_addr({q, rp}),
      .rd_data(ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QC; i++) begin
            wp_ff[i] <= '0;
            rp_ff[i] <= '0;
         end
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept && push_do) begin
            wp_ff[q] <= wp_next;
         end
         if (req_accept && pop_do) begin
            rp_ff[q] <= rp_next;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_status_ff <= s1_status_in;
         s1_pop_ff    <= s1_pop_in;
      end
      if (s1_move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

@@ design/mcfb_checker.sv @@
// Port-level checker for the byte FIFO bank, bound to the top level.
`default_nettype none
`include "multi_channel_byte_fifo_bank_core_macros.svh"
module mcfb_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire mcfb_pkg::rsp_type rsp_data
);

   logic       in_acc, out_acc;
   logic [2:0] pend_ff, pend_in;

   assign in_acc  = req_valid && !req_stall;
   assign out_acc = rsp_valid && !rsp_stall;

   always_comb begin
      pend_in = pend_ff;
      if (in_acc && !out_acc) begin
         pend_in = pend_ff + 3'd1;
      end else if (!in_acc && out_acc) begin
         pend_in = pend_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   `MCFB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled rsp word changed")
   `MCFB_ASSERT_NOW(a_no_phantom, clock, reset, rsp_valid, pend_ff != 3'd0, "rsp word without a pending req")
   `MCFB_ASSERT_NOW(a_depth, clock, reset, 1'b1, pend_ff <= 3'd2, "more than two words in flight")
   `MCFB_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset), !rsp_valid, "rsp valid right after reset")

endmodule

bind multi_channel_byte_fifo_bank_core mcfb_checker u_mcfb_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);
`default_nettype wire

@@ sim/multi_channel_byte_fifo_bank_core_tb.sv @@
// Testbench for the byte FIFO bank core: scoreboard-checked random and directed traffic.
`timescale 1ns / 1ps
module multi_channel_byte_fifo_bank_core_tb;

   localparam int NUM_CH         = mcfb_pkg::NUM_CHANNELS_DEF;
   localparam int DEPTH          = mcfb_pkg::QUEUE_DEPTH_DEF;
   localparam int QUEUES         = 2 * NUM_CH;
   localparam int PTR_W          = $clog2(DEPTH);
   localparam int PHASE_WORDS    = 477;
   localparam int HOLD_AFTER     = 300;
   localparam int HOLD_CYCLES    = 250;
   localparam int DRAIN_CYCLES   = 10;
   localparam int WATCHDOG_LIMIT = 1000;

   class fifo_bank_scoreboard;
      logic [PTR_W-1:0]  wr_ptr [QUEUES];
      logic [PTR_W-1:0]  rd_ptr [QUEUES];
      logic [7:0]        bytes_held [QUEUES][DEPTH];
      mcfb_pkg::rsp_type expected_q [$];
      int                errors;

      function new();
         for (int q = 0; q < QUEUES; q++) begin
            wr_ptr[q] = '0;
            rd_ptr[q] = '0;
         end
         errors = 0;
      endfunction

      function logic [PTR_W-1:0] wrap_next(logic [PTR_W-1:0] p);
         return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
      endfunction

      // Runs one accepted word through the queue model and queues its result.
      function void note_request(mcfb_pkg::req_type w);
         mcfb_pkg::rsp_type r;
         int                q;
         r.data_out = '0;
         r.status   = mcfb_pkg::ST_OK;
         if (int'(w.channel) >= NUM_CH) begin
            r.status = mcfb_pkg::ST_BADCHAN;
         end else begin
            q = int'(w.channel) * 2 + int'(w.direction);
            case (w.action)
               mcfb_pkg::ACT_PUSH: begin
                  if (wrap_next(wr_ptr[q]) == rd_ptr[q]) begin
                     r.status = mcfb_pkg::ST_FULL;
                  end else begin
                     bytes_held[q][wr_ptr[q]] = w.data_in;
                     wr_ptr[q] = wrap_next(wr_ptr[q]);
                  end
               end
               mcfb_pkg::ACT_POP: begin
                  if (rd_ptr[q] == wr_ptr[q]) begin
                     r.status = mcfb_pkg::ST_EMPTY;
                  end else begin
                     r.data_out = bytes_held[q][rd_ptr[q]];
                     rd_ptr[q]  = wrap_next(rd_ptr[q]);
                  end
               end
               mcfb_pkg::ACT_CHECK: begin
                  r.status = (wrap_next(wr_ptr[q]) == rd_ptr[q]) ?
                             mcfb_pkg::ST_FULL : mcfb_pkg::ST_OK;
               end
               default: ;
            endcase
         end
         expected_q.push_back(r);
      endfunction

      function void check_response(mcfb_pkg::rsp_type got);
         mcfb_pkg::rsp_type exp_r;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result word, got data %0h status %0d",
                     $time, got.data_out, got.status);
            errors++;
            return;
         end
         exp_r = expected_q.pop_front();
         if (got.data_out !== exp_r.data_out) begin
            $display("%0t: data_out mismatch, expected %0h actual %0h",
                     $time, exp_r.data_out, got.data_out);
            errors++;
         end
         if (got.status !== exp_r.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, exp_r.status, got.status);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic              clock;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   mcfb_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   mcfb_pkg::rsp_type rsp_data;

   fifo_bank_scoreboard sb;
   int sender_idle_pct = 0;
   int stall_pct       = 0;
   int results_seen    = 0;
   int hold_left       = 0;
   bit hold_done       = 1'b0;

   multi_channel_byte_fifo_bank_core #(
      .NUM_CHANNELS (NUM_CH),
      .QUEUE_DEPTH  (DEPTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic mcfb_pkg::req_type make_word(logic [1:0] act, int ch, int dir,
                                                   int val);
      mcfb_pkg::req_type w;
      w.action    = act;
      w.channel   = 4'(ch);
      w.direction = 1'(dir);
      w.data_in   = 8'(val);
      return w;
   endfunction

   // Offers one word and returns at the edge where it is taken.
   task automatic send_word(input mcfb_pkg::req_type w);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      sb.note_request(w);
   endtask

   task automatic run_directed();
      send_word(make_word(mcfb_pkg::ACT_PUSH, 0, 0, 8'h00));
      send_word(make_word(mcfb_pkg::ACT_PUSH, 0, 0, 8'hFF));
      send_word(make_word(mcfb_pkg::ACT_PUSH, 3, 1, 8'hA5));
      send_word(make_word(mcfb_pkg::ACT_CHECK, 0, 0, 0));
      send_word(make_word(mcfb_pkg::ACT_POP, 0, 0, 8'hFF));
      send_word(make_word(mcfb_pkg::ACT_POP, 0, 0, 0));
      send_word(make_word(mcfb_pkg::ACT_POP, 0, 0, 0));          // empty pop
      send_word(make_word(mcfb_pkg::ACT_POP, 3, 1, 0));
      send_word(make_word(mcfb_pkg::ACT_POP, 3, 1, 0));
      send_word(make_word(mcfb_pkg::ACT_CHECK, 3, 1, 0));
      send_word(make_word(2'd3, 1, 0, 8'h77));         // unused code, valid channel
      send_word(make_word(mcfb_pkg::ACT_PUSH, 4, 0, 8'h11));     // first bad channel
      send_word(make_word(mcfb_pkg::ACT_POP, 15, 1, 0));
      send_word(make_word(mcfb_pkg::ACT_CHECK, 8, 0, 0));
      send_word(make_word(2'd3, 15, 1, 8'hFF));
      send_word(make_word(mcfb_pkg::ACT_PUSH, 2, 1, 8'h5A));
      send_word(make_word(mcfb_pkg::ACT_CHECK, 2, 1, 0));
      send_word(make_word(mcfb_pkg::ACT_PUSH, 1, 0, 8'h3C));
      send_word(make_word(mcfb_pkg::ACT_POP, 1, 0, 0));
      send_word(make_word(mcfb_pkg::ACT_POP, 2, 1, 0));
   endtask

   // Mostly bursts on one queue (fill, drain or mixed) with some raw noise words.
   task automatic run_random(input int n_words);
      int                remaining;
      int                burst;
      int                mode;
      int                ch;
      int                dir;
      int                roll;
      logic [1:0]        act;
      mcfb_pkg::req_type w;
      remaining = n_words;
      while (remaining > 0) begin
         if ($urandom_range(99) < 25) begin
            burst = $urandom_range(1, 8);
            for (int i = 0; i < burst && remaining > 0; i++) begin
               w.action    = 2'($urandom_range(0, 3));
               w.channel   = 4'($urandom_range(0, 15));
               w.direction = 1'($urandom_range(0, 1));
               w.data_in   = 8'($urandom_range(0, 255));
               send_word(w);
               remaining--;
            end
         end else begin
            ch    = $urandom_range(0, NUM_CH - 1);
            dir   = $urandom_range(0, 1);
            mode  = $urandom_range(0, 2);
            burst = $urandom_range(1, 45);
            for (int i = 0; i < burst && remaining > 0; i++) begin
               roll = $urandom_range(99);
               case (mode)
                  0:       act = (roll < 85) ? mcfb_pkg::ACT_PUSH :
                                 (roll < 90) ? mcfb_pkg::ACT_POP : mcfb_pkg::ACT_CHECK;
                  1:       act = (roll < 85) ? mcfb_pkg::ACT_POP :
                                 (roll < 90) ? mcfb_pkg::ACT_PUSH : mcfb_pkg::ACT_CHECK;
                  default: act = (roll < 45) ? mcfb_pkg::ACT_PUSH :
                                 (roll < 90) ? mcfb_pkg::ACT_POP : mcfb_pkg::ACT_CHECK;
               endcase
               send_word(make_word(act, ch, dir, $urandom_range(0, 255)));
               remaining--;
            end
         end
      end
   endtask

   // Result side: checks taken words and drives stall, with one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_response(rsp_data);
            results_seen++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // Ends the run if no word moves on either side for too long.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("** multi_channel_byte_fifo_bank_core: FAILED **");
      $finish;
   end

   initial begin
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct = 6;
      stall_pct       = 64;
      run_directed();
      run_random(PHASE_WORDS);

      sender_idle_pct = 64;
      stall_pct       = 6;
      run_random(PHASE_WORDS);

      sender_idle_pct = 0;
      stall_pct       = 0;
      run_random(PHASE_WORDS);

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.errors == 0 && sb.pending() == 0)
         $display("** multi_channel_byte_fifo_bank_core: PASSED **");
      else
         $display("** multi_channel_byte_fifo_bank_core: FAILED **");
      $finish;
   end

endmodule
